### sv/rsp_pkg.sv
// Package: shared types, codes and constants of the RGB status pattern engine.
`default_nettype none

package rsp_pkg;

	localparam int FIFO_DEPTH_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [3:0] {
		IND_NONE,
		IND_CONNECT,
		IND_PWR_DOWN,
		IND_REBOOT_REL,
		IND_ACCEPTED,
		IND_REJECTED,
		IND_NO_GNSS,
		IND_PUSHED,
		IND_RELEASE,
		IND_RST_FRAME,
		IND_RST_PROG
	} ind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_PERIOD,
		REG_MIN_SATS,
		REG_ON_TIME,
		REG_OFF_TIME,
		REG_GNSS_OFF,
		REG_RAMP_STEP
	} reg_idx_t;

	localparam logic [2:0] PWR_DOWN    = 3'd1;
	localparam logic [2:0] PWR_REBOOT  = 3'd2;
	localparam logic [2:0] PWR_HELD    = 3'd3;
	localparam logic [2:0] PWR_RELEASE = 3'd4;

	localparam logic [1:0] RST_FRAME = 2'd1;
	localparam logic [1:0] RST_PROG  = 2'd2;

	localparam logic [1:0] FS_ACCEPTED = 2'd1;
	localparam logic [1:0] FS_REJECTED = 2'd2;
	localparam logic [1:0] FS_NO_LINK  = 2'd3;

	localparam logic [15:0] DUTY_OFF   = 16'h0000;
	localparam logic [15:0] DUTY_FULL  = 16'hFFFF;
	localparam logic [15:0] DUTY_SOFT  = 16'h5FFF;
	localparam logic [15:0] RAMP_TOP   = 16'd63000;
	localparam logic [15:0] RAMP_BIG   = 16'd3000;
	localparam logic [15:0] RAMP_SMALL = 16'd1500;

	localparam logic [9:0]  LOOP_PERIOD_RST = 10'd10;
	localparam logic [5:0]  MIN_SATS_RST    = 6'd3;
	localparam logic [11:0] ON_TIME_RST     = 12'd50;
	localparam logic [11:0] OFF_TIME_RST    = 12'd1500;
	localparam logic [11:0] GNSS_OFF_RST    = 12'd2000;
	localparam logic [11:0] RAMP_STEP_RST   = 12'd10;
	localparam logic [11:0] ARM_CHANGE_MS   = 12'd1;

	typedef struct packed {
		logic [9:0]  loop_period_ms;
		logic [11:0] on_time_ms;
		logic [11:0] off_time_ms;
		logic [11:0] gnss_off_time_ms;
		logic [11:0] ramp_step_ms;
	} tim_cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_st_t;

endpackage

`default_nettype wire

### sv/rsp_ifs.sv
// Interfaces: status input, duty result and register write channels.
`default_nettype none

interface rsp_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] power_status;
	logic [1:0] reset_status;
	logic       control_power_on;
	logic [1:0] flight_status;
	logic [5:0] satellites;

	modport source (output valid, power_status, reset_status, control_power_on,
		flight_status, satellites, input ready);
	modport sink (input valid, power_status, reset_status, control_power_on,
		flight_status, satellites, output ready);
endinterface

interface rsp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [3:0]  indication;

	modport source (output valid, red_out, green_out, blue_out, indication, input ready);
	modport sink (input valid, red_out, green_out, blue_out, indication, output ready);
endinterface

interface rsp_cfg_if import rsp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/rsp_front.sv
// Front end: accepts status transactions and resolves the indication priority.
`default_nettype none

module rsp_front import rsp_pkg::*; (
	rsp_in_if.sink     status,
	input  logic [5:0] min_satellites,
	input  q_st_t      q_st,
	output logic       push,
	output ind_t       push_ind
);

	assign status.ready = !q_st.full;
	assign push         = status.valid && status.ready;

	always_comb begin
		if (status.power_status == PWR_DOWN)          push_ind = IND_PWR_DOWN;
		else if (status.reset_status == RST_FRAME)    push_ind = IND_RST_FRAME;
		else if (status.power_status == PWR_REBOOT)   push_ind = IND_REBOOT_REL;
		else if (status.reset_status == RST_PROG)     push_ind = IND_RST_PROG;
		else if (status.power_status == PWR_HELD)     push_ind = IND_PUSHED;
		else if (status.power_status == PWR_RELEASE)  push_ind = IND_RELEASE;
		else if (!status.control_power_on)            push_ind = IND_PWR_DOWN;
		else if (status.flight_status == FS_ACCEPTED) push_ind = IND_ACCEPTED;
		else if (status.flight_status == FS_REJECTED)
			push_ind = (status.satellites < min_satellites) ? IND_NO_GNSS : IND_REJECTED;
		else if (status.flight_status == FS_NO_LINK)  push_ind = IND_CONNECT;
		else                                          push_ind = IND_NONE;
	end

endmodule

`default_nettype wire

### sv/rsp_fifo.sv
// Indication queue between front end and pattern back end.
`default_nettype none

module rsp_fifo import rsp_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ind_t                       push_ind,
	input  logic                       pop,
	output ind_t                       pop_ind,
	output q_st_t                      q_st,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ind_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign pop_ind    = mem_q[rd_ptr_q];
	assign q_st.empty = (cnt_q == '0);
	assign q_st.full  = (cnt_q == CNT_FULL);
	assign level      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### sv/rsp_back.sv
// Back end: millisecond timer, pattern sequencer and duty/result registers.
`default_nettype none

module rsp_back import rsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tim_cfg_t   tcfg,
	input  q_st_t      q_st,
	input  ind_t       pop_ind,
	output logic       pop,
	rsp_out_if.source  result
);

	ind_t        prev_q;
	logic        blink_q;
	logic [1:0]  colour_q;
	logic [15:0] ramp_q;
	logic [11:0] left_q;
	logic        run_q;
	logic        exp_q;
	logic [15:0] red_q;
	logic [15:0] grn_q;
	logic [15:0] blu_q;
	ind_t        ind_q;
	logic        valid_q;

	logic        blink_d;
	logic [1:0]  colour_d;
	logic [15:0] ramp_d;
	logic [11:0] left_d;
	logic        run_d;
	logic        exp_d;
	logic [15:0] red_d;
	logic [15:0] grn_d;
	logic [15:0] blu_d;
	logic        changed;
	logic        timed;
	logic        fire;
	logic [11:0] loop_ms;
	logic [15:0] step;
	logic [16:0] ramp_sum;
	logic [11:0] dark_ms;
	logic        red_ramp;

	assign pop               = !q_st.empty && (!valid_q || result.ready);
	assign result.valid      = valid_q;
	assign result.red_out    = red_q;
	assign result.green_out  = grn_q;
	assign result.blue_out   = blu_q;
	assign result.indication = ind_q;

	assign loop_ms  = {2'b00, tcfg.loop_period_ms};
	assign changed  = (pop_ind != prev_q);
	assign timed    = (pop_ind >= IND_CONNECT) && (pop_ind <= IND_NO_GNSS);
	assign step     = (pop_ind == IND_NO_GNSS) ? RAMP_SMALL : RAMP_BIG;
	assign dark_ms  = (pop_ind == IND_NO_GNSS) ? tcfg.gnss_off_time_ms : tcfg.off_time_ms;
	assign red_ramp = (pop_ind != IND_ACCEPTED);
	assign ramp_sum = {1'b0, ramp_q} + {1'b0, step};

	always_comb begin
		blink_d  = blink_q;
		colour_d = colour_q;
		ramp_d   = ramp_q;
		left_d   = left_q;
		run_d    = run_q;
		exp_d    = exp_q;
		red_d    = red_q;
		grn_d    = grn_q;
		blu_d    = blu_q;
		fire     = 1'b0;

		if (run_q) begin
			if (left_q <= loop_ms) begin
				left_d = '0;
				run_d  = 1'b0;
				exp_d  = 1'b1;
			end else begin
				left_d = left_q - loop_ms;
			end
		end

		if (timed) begin
			if (changed) begin
				exp_d  = 1'b0;
				left_d = ARM_CHANGE_MS;
				run_d  = 1'b1;
				if (pop_ind >= IND_ACCEPTED) begin
					ramp_d = '0;
				end
				if (pop_ind == IND_REBOOT_REL) begin
					colour_d = '0;
				end
			end
			if (exp_d) begin
				exp_d = 1'b0;
				fire  = 1'b1;
			end
		end

		unique case (pop_ind) inside
			IND_PWR_DOWN, IND_CONNECT: begin
				if (fire) begin
					run_d = 1'b1;
					if (blink_q) begin
						blink_d = 1'b0;
						red_d   = DUTY_FULL;
						grn_d   = (pop_ind == IND_PWR_DOWN) ? DUTY_FULL : DUTY_OFF;
						blu_d   = DUTY_OFF;
						left_d  = tcfg.on_time_ms;
					end else begin
						blink_d = 1'b1;
						red_d   = DUTY_OFF;
						grn_d   = DUTY_OFF;
						blu_d   = DUTY_OFF;
						left_d  = tcfg.off_time_ms;
					end
				end
			end
			IND_REBOOT_REL: begin
				if (fire) begin
					red_d = DUTY_OFF;
					grn_d = DUTY_OFF;
					blu_d = DUTY_OFF;
					if (colour_d == 2'd0) begin
						colour_d = 2'd1;
						red_d    = DUTY_FULL;
					end else if (colour_d == 2'd1) begin
						colour_d = 2'd2;
						grn_d    = DUTY_FULL;
					end else begin
						colour_d = 2'd0;
						blu_d    = DUTY_FULL;
					end
				end
			end
			IND_ACCEPTED, IND_REJECTED, IND_NO_GNSS: begin
				if (fire) begin
					run_d = 1'b1;
					if (blink_q) begin
						if (ramp_d < RAMP_TOP) begin
							ramp_d = ramp_sum[15:0];
							red_d  = red_ramp ? ramp_sum[15:0] : DUTY_OFF;
							grn_d  = red_ramp ? DUTY_OFF : ramp_sum[15:0];
							blu_d  = DUTY_OFF;
							left_d = tcfg.ramp_step_ms;
						end else begin
							ramp_d  = '0;
							red_d   = DUTY_SOFT;
							grn_d   = DUTY_FULL;
							blu_d   = DUTY_SOFT;
							left_d  = tcfg.on_time_ms;
							blink_d = 1'b0;
						end
					end else begin
						blink_d = 1'b1;
						red_d   = DUTY_OFF;
						grn_d   = DUTY_OFF;
						blu_d   = DUTY_OFF;
						left_d  = dark_ms;
					end
				end
			end
			IND_RST_FRAME: begin
				red_d = DUTY_FULL;
				grn_d = DUTY_FULL;
				blu_d = DUTY_OFF;
			end
			IND_RST_PROG: begin
				red_d = DUTY_FULL;
				grn_d = DUTY_FULL;
				blu_d = DUTY_FULL;
			end
			IND_PUSHED: begin
				red_d = DUTY_OFF;
				grn_d = DUTY_OFF;
				blu_d = DUTY_FULL;
			end
			IND_RELEASE: begin
				red_d = DUTY_SOFT;
				grn_d = DUTY_FULL;
				blu_d = DUTY_SOFT;
			end
			default: begin
				red_d = DUTY_OFF;
				grn_d = DUTY_OFF;
				blu_d = DUTY_OFF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= IND_NONE;
			blink_q  <= 1'b0;
			colour_q <= '0;
			ramp_q   <= '0;
			left_q   <= '0;
			run_q    <= 1'b0;
			exp_q    <= 1'b0;
			red_q    <= '0;
			grn_q    <= '0;
			blu_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				prev_q   <= pop_ind;
				blink_q  <= blink_d;
				colour_q <= colour_d;
				ramp_q   <= ramp_d;
				left_q   <= left_d;
				run_q    <= run_d;
				exp_q    <= exp_d;
				red_q    <= red_d;
				grn_q    <= grn_d;
				blu_q    <= blu_d;
				valid_q  <= 1'b1;
			end else if (result.ready) begin
				valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ind_q <= pop_ind;
		end
	end

endmodule

`default_nettype wire

### sv/rgb_status_pattern_engine.sv
// Top level: RGB status pattern engine with register file and assertions.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+--------------------------------------------------
//  status   | in  | valid/ready  | power/reset/flight status, power on, satellites
//  result   | out | valid/ready  | red_out, green_out, blue_out, indication
//  cfg      | in  | valid/ready  | index (0..5), data (12 bits, low bits used)
//
// One status transaction per cycle sustained while result.ready stays high; queue depth FIFO_DEPTH.
// A result is registered at the earliest through the queue write on the accepting edge
// and then the pattern step into the result register.
// The pattern step and the result register together set the one-per-cycle rate while result.ready is high.
// Reset clears queue, timer, pattern state and duties; registers take defaults.
// result.ready low fills the queue, then status.ready drops; cfg.ready is always high.
`default_nettype none

module rgb_status_pattern_engine import rsp_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rsp_in_if.sink     status,
	rsp_out_if.source  result,
	rsp_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(FIFO_DEPTH+1);

	tim_cfg_t         tcfg_q;
	logic [5:0]       min_sats_q;
	q_st_t            q_st;
	logic             push;
	ind_t             push_ind;
	logic             pop;
	ind_t             pop_ind;
	logic [CNT_W-1:0] level;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.loop_period_ms   <= LOOP_PERIOD_RST;
			min_sats_q              <= MIN_SATS_RST;
			tcfg_q.on_time_ms       <= ON_TIME_RST;
			tcfg_q.off_time_ms      <= OFF_TIME_RST;
			tcfg_q.gnss_off_time_ms <= GNSS_OFF_RST;
			tcfg_q.ramp_step_ms     <= RAMP_STEP_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_LOOP_PERIOD: tcfg_q.loop_period_ms   <= cfg.data[9:0];
				REG_MIN_SATS:    min_sats_q              <= cfg.data[5:0];
				REG_ON_TIME:     tcfg_q.on_time_ms       <= cfg.data;
				REG_OFF_TIME:    tcfg_q.off_time_ms      <= cfg.data;
				REG_GNSS_OFF:    tcfg_q.gnss_off_time_ms <= cfg.data;
				REG_RAMP_STEP:   tcfg_q.ramp_step_ms     <= cfg.data;
				default: ;
			endcase
		end
	end

	rsp_front u_front (
		.status         (status),
		.min_satellites (min_sats_q),
		.q_st           (q_st),
		.push           (push),
		.push_ind       (push_ind)
	);

	rsp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ind (push_ind),
		.pop      (pop),
		.pop_ind  (pop_ind),
		.q_st     (q_st),
		.level    (level)
	);

	rsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tcfg    (tcfg_q),
		.q_st    (q_st),
		.pop_ind (pop_ind),
		.pop     (pop),
		.result  (result)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= CNT_W'(FIFO_DEPTH))
		else $error("queue level beyond depth");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level == $past(level) + CNT_W'(1)))
		else $error("queue level lost a transaction");

	a_rst_prog: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.indication == IND_RST_PROG) |->
		(result.red_out == DUTY_FULL && result.green_out == DUTY_FULL &&
		 result.blue_out == DUTY_FULL))
		else $error("reset in progress not white");

	a_none_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.indication == IND_NONE) |->
		(result.red_out == DUTY_OFF && result.green_out == DUTY_OFF &&
		 result.blue_out == DUTY_OFF))
		else $error("no indication but duty nonzero");

endmodule

`default_nettype wire
